// ===== rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/wsfp_pkg.sv =====
`timescale 1ns / 1ps

package wsfp_pkg;

  localparam logic       KIND_HEADER  = 1'b0;
  localparam logic       KIND_PAYLOAD = 1'b1;

  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;

  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef struct packed {
    logic [3:0] opcode;
    logic       fin;
    logic [2:0] rsv;
    logic       mask;
  } hdr_t;

  typedef struct packed {
    logic       kind;
    logic       frame_end;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    hdr_t       hdr;
  } rec_t;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

endpackage

// ===== rtl/wsfp_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsfp_front #(
  parameter int LENGTH_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_stream_byte,
  input  logic                   queue_full,
  output logic                   push,
  output wsfp_pkg::rec_t         push_rec,
  output logic [LENGTH_BITS-1:0] push_len
);
  import wsfp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  hdr_t                   hdr_r, hdr_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             kidx_r, kidx_nxt;
  logic                   accept;
  logic                   finish;
  logic [6:0]             code;
  logic [7:0]             key_sel;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign code     = in_stream_byte[6:0];
  assign rem_dec  = rem_r - LENGTH_BITS'(1);

  always_comb begin
    case (kidx_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt          = phase_r;
    hdr_nxt            = hdr_r;
    len_nxt            = len_r;
    rem_nxt            = rem_r;
    cnt_nxt            = cnt_r;
    key_nxt            = key_r;
    kidx_nxt           = kidx_r;
    finish             = 1'b0;
    push               = 1'b0;
    push_rec.kind      = KIND_HEADER;
    push_rec.frame_end = 1'b0;
    push_rec.raw_byte  = 8'd0;
    push_rec.key_byte  = 8'd0;
    if (accept) begin
      case (phase_r)
        PH_SECOND: begin
          hdr_nxt.mask = in_stream_byte[7];
          key_nxt      = '0;
          if (code != LEN_CODE_16 && code != LEN_CODE_64) begin
            len_nxt = LENGTH_BITS'(code);
            if (in_stream_byte[7]) begin
              cnt_nxt   = KEY_BYTES;
              phase_nxt = PH_KEY;
            end else begin
              finish = 1'b1;
            end
          end else begin
            len_nxt   = '0;
            cnt_nxt   = (code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          len_nxt = {len_r[LENGTH_BITS-9:0], in_stream_byte};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            if (hdr_r.mask) begin
              cnt_nxt   = KEY_BYTES;
              phase_nxt = PH_KEY;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], in_stream_byte};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            finish = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push              = 1'b1;
          push_rec.kind     = KIND_PAYLOAD;
          push_rec.raw_byte = in_stream_byte;
          push_rec.key_byte = hdr_r.mask ? key_sel : 8'd0;
          kidx_nxt          = kidx_r + 2'd1;
          rem_nxt           = rem_dec;
          if (rem_dec == '0) begin
            push_rec.frame_end = 1'b1;
            phase_nxt          = PH_FIRST;
          end
        end
        default: begin
          hdr_nxt.fin    = in_stream_byte[7];
          hdr_nxt.rsv    = in_stream_byte[6:4];
          hdr_nxt.opcode = in_stream_byte[3:0];
          phase_nxt      = PH_SECOND;
        end
      endcase
      if (finish) begin
        push     = 1'b1;
        kidx_nxt = 2'd0;
        rem_nxt  = len_nxt;
        if (len_nxt == '0) begin
          push_rec.frame_end = 1'b1;
          phase_nxt          = PH_FIRST;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
    push_rec.hdr = hdr_nxt;
    push_len     = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      hdr_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      kidx_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  `ASSERT_NEVER(a_payload_nonempty, clk, rst_n, phase_r == PH_PAYLOAD && rem_r == '0, "payload phase with nothing left")
  `ASSERT_IMPLY(a_payload_kind, clk, rst_n, push && phase_r == PH_PAYLOAD, push_rec.kind == KIND_PAYLOAD, "payload byte pushed as header")

endmodule

// ===== rtl/wsfp_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !not_empty, "pop from empty queue")

endmodule

// ===== rtl/wsfp_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsfp_back #(
  parameter int LENGTH_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  wsfp_pkg::rec_t         q_rec,
  input  logic [LENGTH_BITS-1:0] q_len,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_record_kind,
  output logic [7:0]             out_payload_byte,
  output logic [3:0]             out_frame_opcode,
  output logic                   out_final_fragment,
  output logic [2:0]             out_reserved_bits,
  output logic                   out_is_masked,
  output logic [LENGTH_BITS-1:0] out_frame_len,
  output logic                   out_frame_end
);
  import wsfp_pkg::*;

  logic                   valid_r, valid_nxt;
  rec_t                   rec_r;
  logic [7:0]             byte_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   load;
  logic                   hdr_out;

  assign load    = q_valid && (!valid_r || !out_stall);
  assign pop     = load;
  assign hdr_out = valid_r && (rec_r.kind == KIND_HEADER);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // unmask on the way out
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= q_rec;
      byte_r <= q_rec.raw_byte ^ q_rec.key_byte;
      len_r  <= q_len;
    end
  end

  assign out_valid          = valid_r;
  assign out_record_kind    = rec_r.kind;
  assign out_payload_byte   = byte_r;
  assign out_frame_opcode   = rec_r.hdr.opcode;
  assign out_final_fragment = rec_r.hdr.fin;
  assign out_reserved_bits  = rec_r.hdr.rsv;
  assign out_is_masked      = rec_r.hdr.mask;
  assign out_frame_len      = len_r;
  assign out_frame_end      = rec_r.frame_end;

  `ASSERT_IMPLY(a_header_byte_zero, clk, rst_n, hdr_out, byte_r == 8'd0, "header byte set")

endmodule

// ===== rtl/websocket_frame_parser.sv =====
`timescale 1ns / 1ps
// path: the record is pushed into the queue when the byte that completes it is taken, then moves to the out_* register
// throughput: one stream byte per cycle while in_stall is low (queue not full), set by the parser state update
// a queue of QUEUE_DEPTH records lets the parser keep taking bytes while out_stall is high, until the queue is full
// reset: synchronous active-low rst_n, parser returns to expecting a first header byte
// and the queue and output register are emptied

module websocket_frame_parser #(
  parameter int LENGTH_BITS = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_stream_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_record_kind,
  output logic [7:0]             out_payload_byte,
  output logic [3:0]             out_frame_opcode,
  output logic                   out_final_fragment,
  output logic [2:0]             out_reserved_bits,
  output logic                   out_is_masked,
  output logic [LENGTH_BITS-1:0] out_frame_len,
  output logic                   out_frame_end
);
  import wsfp_pkg::*;

  localparam int ENTRY_W = $bits(rec_t) + LENGTH_BITS;

  logic                   push;
  rec_t                   push_rec;
  logic [LENGTH_BITS-1:0] push_len;
  logic                   q_full;
  logic                   q_valid;
  logic                   pop;
  logic [ENTRY_W-1:0]     q_data;
  rec_t                   q_rec;
  logic [LENGTH_BITS-1:0] q_len;

  wsfp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .queue_full     (q_full),
    .push           (push),
    .push_rec       (push_rec),
    .push_len       (push_len)
  );

  wsfp_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_rec, push_len}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign q_rec = q_data[ENTRY_W-1:LENGTH_BITS];
  assign q_len = q_data[LENGTH_BITS-1:0];

  wsfp_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rec              (q_rec),
    .q_len              (q_len),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_payload_byte   (out_payload_byte),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_reserved_bits  (out_reserved_bits),
    .out_is_masked      (out_is_masked),
    .out_frame_len      (out_frame_len),
    .out_frame_end      (out_frame_end)
  );

endmodule
